@@ rtl/core/rdi_pkg.sv @@
// rdi_pkg: shared types and constants of the radial distance inversion block
// no dependencies
package rdi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SumW   = 64;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_MEASURE   = 2'd1,
    OP_TRANSFORM = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  // one classified word between front and back
  typedef struct packed {
    op_e                      op;
    logic [2:0]               sgn;
    logic [2:0][CoordW-1:0]   mag;
  } job_t;

endpackage

@@ rtl/core/rdi_if.sv @@
// rdi_in_if and rdi_out_if: valid/ready channels of the block
// depends on rdi_pkg for widths
interface rdi_in_if;
  import rdi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  modport source (output valid, opcode, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, coord_z, output ready);
endinterface

interface rdi_out_if;
  import rdi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] out_z;
  logic                     clipped;
  logic                     zero_length;
  modport source (output valid, out_x, out_y, out_z, clipped, zero_length, input ready);
  modport sink   (input valid, out_x, out_y, out_z, clipped, zero_length, output ready);
endinterface

@@ rtl/core/rdi_fifo.sv @@
// rdi_fifo: two-entry queue of classified words between front and back
// depends on rdi_pkg
module rdi_fifo import rdi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_data_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ rtl/core/rdi_front.sv @@
// rdi_front: accepts input words, drops unused opcodes, splits sign and magnitude
// depends on rdi_pkg and rdi_in_if
module rdi_front import rdi_pkg::*; (
  rdi_in_if.sink in_i,
  input  logic   full_i,
  output logic   push_o,
  output job_t   job_o
);

  logic [2:0][CoordW-1:0] c;

  assign c[0] = in_i.coord_x;
  assign c[1] = in_i.coord_y;
  assign c[2] = in_i.coord_z;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && (op_e'(in_i.opcode) != OP_UNUSED);

  // magnitude and sign of each coordinate
  always_comb begin
    job_o.op = op_e'(in_i.opcode);
    for (int i = 0; i < 3; i++) begin
      job_o.sgn[i] = c[i][CoordW-1];
      job_o.mag[i] = c[i][CoordW-1] ? (~c[i] + 1'b1) : c[i];
    end
  end

endmodule

@@ rtl/core/rdi_back.sv @@
// rdi_back: sequencer for squares, square root, statistics and division
// depends on rdi_pkg and rdi_out_if
module rdi_back import rdi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  rdi_out_if.source out_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_ROOT  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_DINIT = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  job_t                   job_q;
  logic [5:0]             cnt_q;
  logic [1:0]             ci_q;
  logic [SumW-1:0]        sum_q;
  logic [33:0]            rem_q;
  logic [CoordW-1:0]      root_q;
  logic [CoordW:0]        quo_q;
  logic [SumW-1:0]        prod_q;
  logic                   ovf_q;
  logic [CoordW:0]        nmag_q;
  logic                   nsgn_q;
  logic [CoordW-1:0]      near_q, far_q;
  logic                   seen_q;
  logic [2:0][CoordW-1:0] res_q;
  logic                   clip_q, zl_q;
  logic                   ov_q;
  logic [CoordW-1:0]      ox_q, oy_q, oz_q;
  logic                   oclip_q, ozl_q;

  // datapath helpers
  logic [CoordW-1:0] sq_sel, c_sel;
  logic [SumW-1:0]   sq_prod;
  logic [34:0]       rt_rem, rt_trial;
  logic              rt_ge;
  logic [33:0]       nd;
  logic [SumW:0]     mul_full;
  logic [33:0]       dv_rem;
  logic              dv_ge;
  logic              fin_neg;
  logic [CoordW-1:0] fin_val;
  logic              fin_clip;
  logic              emit_ok;

  assign sq_sel   = job_q.mag[cnt_q[1:0]];
  assign sq_prod  = {32'b0, sq_sel} * {32'b0, sq_sel};
  assign rt_rem   = {rem_q[32:0], sum_q[SumW-1 -: 2]};
  assign rt_trial = {1'b0, root_q, 2'b01};
  assign rt_ge    = rt_rem >= rt_trial;
  assign nd       = {2'b0, near_q} + {2'b0, far_q} - {2'b0, root_q};
  assign c_sel    = job_q.mag[ci_q];
  assign mul_full = {33'b0, c_sel} * {32'b0, nmag_q};
  assign dv_rem   = {rem_q[32:0], prod_q[SumW-1]};
  assign dv_ge    = dv_rem >= {2'b0, root_q};
  assign emit_ok  = !ov_q || out_o.ready;
  assign pop_o    = (state_q == S_IDLE) && job_valid_i;

  // sign and saturation of one finished quotient
  always_comb begin
    fin_neg = job_q.sgn[ci_q] ^ nsgn_q;
    if (fin_neg) begin
      fin_clip = ovf_q || (quo_q > 33'h080000000);
      fin_val  = fin_clip ? 32'h80000000 : (~quo_q[CoordW-1:0] + 1'b1);
    end else begin
      fin_clip = ovf_q || (quo_q > 33'h07fffffff);
      fin_val  = fin_clip ? 32'h7fffffff : quo_q[CoordW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (job_valid_i && job_i.op != OP_CLEAR) state_d = S_SQ;
      S_SQ:    if (cnt_q == 6'd2) state_d = S_ROOT;
      S_ROOT:  if (cnt_q == 6'd31) state_d = S_EVAL;
      S_EVAL: begin
        if (job_q.op != OP_TRANSFORM) state_d = S_IDLE;
        else if (root_q == '0)        state_d = S_EMIT;
        else                          state_d = S_MUL;
      end
      S_MUL:   state_d = S_DINIT;
      S_DINIT: state_d = S_DIV;
      S_DIV:   if (cnt_q == 6'd32) state_d = S_FIN;
      S_FIN:   state_d = (ci_q == 2'd2) ? S_EMIT : S_MUL;
      S_EMIT:  if (emit_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        job_q <= job_i;
        sum_q <= '0;
      end
      S_SQ: begin
        sum_q  <= sum_q + sq_prod;
        rem_q  <= '0;
        root_q <= '0;
      end
      S_ROOT: begin
        rem_q  <= rt_ge ? 34'(rt_rem - rt_trial) : rt_rem[33:0];
        root_q <= {root_q[CoordW-2:0], rt_ge};
        sum_q  <= sum_q << 2;
      end
      S_EVAL: begin
        nsgn_q <= nd[33];
        nmag_q <= nd[33] ? 33'(~nd + 1'b1) : nd[CoordW:0];
        clip_q <= 1'b0;
        zl_q   <= (root_q == '0);
        res_q  <= '0;
      end
      S_MUL:   prod_q <= mul_full[SumW-1:0];
      S_DINIT: begin
        rem_q  <= {3'b0, prod_q[SumW-1:33]};
        ovf_q  <= prod_q[SumW-1:33] >= root_q[30:0] && root_q[31] == 1'b0;
        prod_q <= prod_q << 31;
        quo_q  <= '0;
      end
      S_DIV: begin
        rem_q  <= dv_ge ? (dv_rem - {2'b0, root_q}) : dv_rem;
        quo_q  <= {quo_q[CoordW-1:0], dv_ge};
        prod_q <= prod_q << 1;
      end
      S_FIN: begin
        res_q[ci_q] <= fin_val;
        clip_q      <= clip_q | fin_clip;
      end
      default: ;
    endcase
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && emit_ok) begin
      ox_q    <= res_q[0];
      oy_q    <= res_q[1];
      oz_q    <= res_q[2];
      oclip_q <= clip_q;
      ozl_q   <= zl_q;
    end
  end

  // control, counters and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ci_q    <= '0;
      near_q  <= '0;
      far_q   <= '0;
      seen_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // output valid: set on emit, cleared when taken
      if (state_q == S_EMIT && emit_ok) ov_q <= 1'b1;
      else if (out_o.ready)             ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (job_valid_i && job_i.op == OP_CLEAR) begin
            near_q <= '0;
            far_q  <= '0;
            seen_q <= 1'b0;
          end
        end
        S_SQ:   cnt_q <= (cnt_q == 6'd2) ? 6'd0 : cnt_q + 6'd1;
        S_ROOT: cnt_q <= cnt_q + 6'd1;
        S_EVAL: begin
          ci_q <= '0;
          if (job_q.op == OP_MEASURE) begin
            if (!seen_q || root_q < near_q) begin
              near_q <= root_q;
              seen_q <= 1'b1;
            end
            if (root_q > far_q) far_q <= root_q;
          end
        end
        S_DINIT: cnt_q <= '0;
        S_DIV:   cnt_q <= cnt_q + 6'd1;
        S_FIN:   ci_q  <= ci_q + 2'd1;
        default: ;
      endcase
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_x       = ox_q;
  assign out_o.out_y       = oy_q;
  assign out_o.out_z       = oz_q;
  assign out_o.clipped     = oclip_q;
  assign out_o.zero_length = ozl_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni) seen_q |-> near_q <= far_q)
    else $error("near distance above far distance");
  a_divcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q <= 6'd32)
    else $error("divider step count out of range");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && job_q.op == OP_TRANSFORM && root_q == '0) |=> state_q == S_EMIT)
    else $error("zero-length vertex did not go straight to emit");

endmodule

@@ rtl/core/radial_distance_inversion.sv @@
// radial_distance_inversion: top level, front classifier, queue and back sequencer
// depends on rdi_pkg, rdi_if, rdi_front, rdi_fifo, rdi_back
//
// channel  dir  payload                                    words
// in_i     in   opcode, coord_x, coord_y, coord_z          one vertex or command
// out_o    out  out_x, out_y, out_z, clipped, zero_length  one per transform
//
// clear is done in the idle state; measure: pop, 3 squares, 32 root steps, update;
// transform: root as above, then per coordinate multiply, divider setup, the
// one-bit-per-cycle divider and saturation, then emit; the back takes no new word
// until idle again; reset clears the statistics, the queue and the output valid
// flag; the front keeps accepting while the two-entry queue has room; a result
// waiting in the output register stalls the back only at its next result
module radial_distance_inversion import rdi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rdi_in_if.sink    in_i,
  rdi_out_if.source out_o
);

  logic push, full, pop, qvalid;
  job_t push_job, pop_job;

  rdi_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  rdi_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_job)
  );

  rdi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qvalid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

@@ test/rdi_tb_if.sv @@
// rdi_tb_types: word types the testbench uses for stimulus and prediction
// depends on rdi_pkg; the channel interfaces come from rtl/core/rdi_if.sv
package rdi_tb_types;
  import rdi_pkg::*;
  // one vertex or command word as the testbench sees it
  typedef struct {
    op_e         op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vert_word_t;
  // one moved vertex word
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clipped;
    logic        zero_length;
  } moved_word_t;
endpackage

@@ test/rdi_checker.sv @@
// rdi_checker: watches both channels, predicts moved vertices and compares them
// depends on rdi_pkg, rdi_tb_types and the rdi_in_if / rdi_out_if interfaces
module rdi_checker import rdi_pkg::*, rdi_tb_types::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rdi_in_if  in_i,
  rdi_out_if out_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] near_dist, far_dist;
  logic        near_valid;
  moved_word_t moved_q[$];

  assign pending_o = moved_q.size();

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic logic [63:0] root_floor(input logic [65:0] v);
    logic [65:0] r, b;
    r = '0;
    b = 66'd1 << 64;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] radius(input vert_word_t w);
    longint ax, ay, az;
    logic [65:0] sum;
    ax = longint'($signed(w.x)); if (ax < 0) ax = -ax;
    ay = longint'($signed(w.y)); if (ay < 0) ay = -ay;
    az = longint'($signed(w.z)); if (az < 0) az = -az;
    sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
    return root_floor(sum);
  endfunction

  // c * newd / d truncated toward zero, then saturated
  function automatic logic [31:0] slide(input logic [31:0] c, input longint newd,
                                        input logic [63:0] d, inout logic clip);
    longint sc;
    logic [63:0] mc, mn;
    logic [127:0] q;
    logic neg;
    sc = longint'($signed(c));
    mc = (sc < 0) ? 64'(-sc) : 64'(sc);
    mn = (newd < 0) ? 64'(-newd) : 64'(newd);
    q = (128'(mc) * 128'(mn)) / 128'(d);
    neg = (sc < 0) != (newd < 0);
    if (neg) begin
      if (q > 128'h8000_0000) begin clip = 1'b1; q = 128'h8000_0000; end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin clip = 1'b1; q = 128'h7FFF_FFFF; end
    return q[31:0];
  endfunction

  // fold one accepted word into the statistics or the expected queue
  task automatic absorb(input vert_word_t w);
    logic [63:0] d;
    longint newd;
    moved_word_t m;
    if (w.op == OP_CLEAR) begin
      near_dist = '0; far_dist = '0; near_valid = 1'b0;
      return;
    end
    if (w.op == OP_UNUSED) return;
    d = radius(w);
    if (w.op == OP_MEASURE) begin
      if (!near_valid || d < 64'(near_dist)) begin
        near_dist = d[31:0];
        near_valid = 1'b1;
      end
      if (d > 64'(far_dist)) far_dist = d[31:0];
      return;
    end
    m = '{x: '0, y: '0, z: '0, clipped: 1'b0, zero_length: 1'b0};
    if (d == 0) begin
      m.zero_length = 1'b1;
    end else begin
      newd = longint'(near_dist) + longint'(far_dist) - longint'(d);
      m.x = slide(w.x, newd, d, m.clipped);
      m.y = slide(w.y, newd, d, m.clipped);
      m.z = slide(w.z, newd, d, m.clipped);
    end
    moved_q.push_back(m);
  endtask

  // sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    vert_word_t w;
    moved_word_t e;
    if (!rst_ni) begin
      near_dist = '0; far_dist = '0; near_valid = 1'b0;
      moved_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        if (moved_q.size() == 0) begin
          report("moved vertex with none expected");
        end else begin
          e = moved_q.pop_front();
          if (out_o.out_x !== e.x)
            report($sformatf("out_x %h want %h", out_o.out_x, e.x));
          if (out_o.out_y !== e.y)
            report($sformatf("out_y %h want %h", out_o.out_y, e.y));
          if (out_o.out_z !== e.z)
            report($sformatf("out_z %h want %h", out_o.out_z, e.z));
          if (out_o.clipped !== e.clipped)
            report($sformatf("clipped %b want %b", out_o.clipped, e.clipped));
          if (out_o.zero_length !== e.zero_length)
            report($sformatf("zero_length %b want %b", out_o.zero_length, e.zero_length));
        end
      end
      if (in_i.valid && in_i.ready) begin
        w.op = op_e'(in_i.opcode);
        w.x = in_i.coord_x; w.y = in_i.coord_y; w.z = in_i.coord_z;
        absorb(w);
      end
    end
  end
endmodule

@@ test/tb.sv @@
// tb: clock, reset, stimulus and verdict for radial_distance_inversion
// depends on rdi_pkg, rdi_tb_types, the rtl interfaces and rdi_checker
module tb;
  import rdi_pkg::*;
  import rdi_tb_types::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending;
  int unsigned send_idle_pct, recv_stall_pct;

  rdi_in_if  in_ch();
  rdi_out_if out_ch();

  radial_distance_inversion u_top (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));
  rdi_checker u_chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
                     .fail_count_o(fail_count), .pending_o(pending));

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // present one word and hold it until it is taken
  task automatic send_word(input op_e op, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // coordinate mixing extremes, small and full-range values
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // stop sending and wait until every expected word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // one mesh fed twice: clear, measure pass, transform pass
  task automatic mesh_pass(input int n);
    logic [31:0] vx[$], vy[$], vz[$];
    for (int i = 0; i < n; i++) begin
      vx.push_back(pick_coord()); vy.push_back(pick_coord()); vz.push_back(pick_coord());
    end
    send_word(OP_CLEAR, $urandom, $urandom, $urandom);
    foreach (vx[i]) send_word(OP_MEASURE, vx[i], vy[i], vz[i]);
    foreach (vx[i]) send_word(OP_TRANSFORM, vx[i], vy[i], vz[i]);
  endtask

  initial begin
    int sent;
    int n;
    op_e op;
    in_ch.valid = 1'b0; in_ch.opcode = OP_CLEAR;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: transform before any measure, origin, extremes, unused opcode
    send_word(OP_TRANSFORM, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_word(OP_TRANSFORM, '0, '0, '0);
    send_word(OP_MEASURE, '0, '0, '0);
    send_word(OP_MEASURE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_TRANSFORM, '0, '0, '0);
    send_word(OP_TRANSFORM, 32'h0000_0001, '0, '0);
    send_word(OP_TRANSFORM, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(OP_TRANSFORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_UNUSED, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_MEASURE, 32'h0003_0000, 32'h0004_0000, '0);
    send_word(OP_MEASURE, 32'h0000_0000, 32'h0001_0000, '0);
    send_word(OP_TRANSFORM, 32'h0003_0000, 32'h0004_0000, '0);
    send_word(OP_TRANSFORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_TRANSFORM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // hold the sender until every moved vertex is back
    drain();

    // random: mostly well-formed mesh passes, some loose words, four phases: none, sender idle, receiver stall, both
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 62 : 37) : 0;
      recv_stall_pct = (phase == 2) ? 62 : ((phase == 3) ? 37 : 0);
      while (sent < 450 * (phase + 1)) begin
        if ($urandom_range(9) < 8) begin
          n = $urandom_range(1, 12);
          mesh_pass(n);
          sent += 2 * n + 1;
        end else begin
          op = op_e'($urandom_range(3));
          send_word(op, pick_coord(), pick_coord(), pick_coord());
          if (op != OP_UNUSED) sent++;
        end
      end
    end
    drain();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
